// File: src/ppmfr_pkg.sv
// ppmfr_pkg: payload types and fixed widths for the ppm face reconstruction pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package ppmfr_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FLAT_W   = 17;
	// neighbor difference, doubled limited slope, twelve-times face value
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int SLOPE_W  = SAMPLE_W + 3;
	localparam int FACE_W   = 40;
	localparam int PROD_W   = FACE_W + FLAT_W + 1;

	// the divide by three works on base-4 digits, split over three stages
	localparam int DIV_DIGITS = FACE_W / 2;
	localparam int DIV_A_DIG  = 7;
	localparam int DIV_B_DIG  = 7;
	localparam int DIV_C_DIG  = DIV_DIGITS - DIV_A_DIG - DIV_B_DIG;

	// bias that makes the dividend non-negative, and its image after the divide
	localparam logic [FACE_W-1:0] DIV_BIAS   = 40'hC0_0000_0000;
	localparam logic [FACE_W-1:0] DIV_UNBIAS = 40'h40_0000_0000;

	localparam logic signed [FACE_W-1:0] SAT_MAX = 40'sh00_7FFF_FFFF;
	localparam logic signed [FACE_W-1:0] SAT_MIN = -40'sh00_8000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_m2;
		logic signed [SAMPLE_W-1:0] sample_m1;
		logic signed [SAMPLE_W-1:0] sample_center;
		logic signed [SAMPLE_W-1:0] sample_p1;
		logic signed [SAMPLE_W-1:0] sample_p2;
		logic        [FLAT_W-1:0]   flattening;
	} stencil_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] face_upper;
		logic signed [SAMPLE_W-1:0] face_lower;
	} face_t;

endpackage

`default_nettype wire

// File: src/ppmfr_mc_slope.sv
// ppmfr_mc_slope: monotonized-central limiter, result held as twice the slope
// depends on ppmfr_pkg for widths
`default_nettype none

module ppmfr_mc_slope
	import ppmfr_pkg::*;
(
	input  logic signed [DIFF_W-1:0]  dl,
	input  logic signed [DIFF_W-1:0]  dr,
	output logic signed [SLOPE_W-1:0] slope
);

	logic signed [DIFF_W:0]  sum;
	logic        [DIFF_W:0]  sum_mag;
	logic        [DIFF_W-1:0] dl_mag;
	logic        [DIFF_W-1:0] dr_mag;
	logic        [SLOPE_W-1:0] dl_lim;
	logic        [SLOPE_W-1:0] dr_lim;
	logic        [SLOPE_W-1:0] min_mag;
	logic                     same_sign;

	// magnitudes of the centered sum and of four times each one-sided difference
	always_comb begin
		sum       = (DIFF_W+1)'(dl) + (DIFF_W+1)'(dr);
		sum_mag   = sum[DIFF_W] ? (DIFF_W+1)'(-sum) : sum;
		dl_mag    = dl[DIFF_W-1] ? DIFF_W'(-dl) : dl;
		dr_mag    = dr[DIFF_W-1] ? DIFF_W'(-dr) : dr;
		dl_lim    = {dl_mag, 2'b00};
		dr_lim    = {dr_mag, 2'b00};
		same_sign = (!dl[DIFF_W-1] && dl != '0 && !dr[DIFF_W-1] && dr != '0) ||
		            (dl[DIFF_W-1] && dr[DIFF_W-1]);
	end

	// three-way minimum, signed like the centered sum, zero across a sign change or where either difference is zero
	always_comb begin
		min_mag = SLOPE_W'(sum_mag);
		if (dl_lim < min_mag) begin
			min_mag = dl_lim;
		end
		if (dr_lim < min_mag) begin
			min_mag = dr_lim;
		end
		if (!same_sign) begin
			slope = '0;
		end else if (sum[DIFF_W]) begin
			slope = -$signed(min_mag);
		end else begin
			slope = $signed(min_mag);
		end
	end

endmodule

`default_nettype wire

// File: src/ppmfr_div3_step.sv
// ppmfr_div3_step: NDIG base-4 digits of a long division by three
// depends on ppmfr_pkg; chained across pipeline stages by the top level
`default_nettype none

module ppmfr_div3_step
	import ppmfr_pkg::*;
#(
	parameter int NDIG = 7
) (
	input  logic [1:0]        rem_in,
	input  logic [2*NDIG-1:0] dig_in,
	output logic [2*NDIG-1:0] quo,
	output logic [1:0]        rem_out
);

	logic [3:0] part;
	logic [1:0] qd;
	logic [1:0] r;

	// most significant digit first, remainder stays below three
	always_comb begin
		r   = rem_in;
		quo = '0;
		for (int k = NDIG - 1; k >= 0; k--) begin
			part = {r, dig_in[2*k +: 2]};
			if (part >= 4'd9) begin
				qd = 2'd3;
			end else if (part >= 4'd6) begin
				qd = 2'd2;
			end else if (part >= 4'd3) begin
				qd = 2'd1;
			end else begin
				qd = 2'd0;
			end
			r = 2'(part - 4'(qd) * 4'd3);
			quo[2*k +: 2] = qd;
		end
		rem_out = r;
	end

endmodule

`default_nettype wire

// File: src/ppm_face_reconstruction.sv
// ppm_face_reconstruction: nine-stage pipeline from accepted stencil to result
// one stencil per cycle sustained unless the result is held; the stages are slopes, faces,
// flattening multiply, bias, three divide-by-three stages, overshoot tests, correction, saturation
// a held result freezes the whole pipeline and the input stall follows it
// reset clears the stage valid bits only; the pipeline comes out of reset empty
// depends on ppmfr_pkg, ppmfr_mc_slope, ppmfr_div3_step
`default_nettype none

module ppm_face_reconstruction
	import ppmfr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     stencil_valid,
	output logic     stencil_stall,
	input  stencil_t stencil,
	output logic     face_valid,
	input  logic     face_stall,
	output face_t    face
);

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic en;
	logic [9:1] vld;

	// whole pipeline advances unless the result register is held
	assign en            = !(vld[9] && face_stall);
	assign stencil_stall = vld[9] && face_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[8:1], stencil_valid};
		end
	end

	// stage 1: limited slopes at the three cells
	logic signed [DIFF_W-1:0]  d_ml, d_cl, d_cr, d_pr;
	logic signed [SLOPE_W-1:0] sm, s0, sp;
	logic        [FLAT_W-1:0]  w_eff;

	assign d_ml = DIFF_W'(stencil.sample_m1) - DIFF_W'(stencil.sample_m2);
	assign d_cl = DIFF_W'(stencil.sample_center) - DIFF_W'(stencil.sample_m1);
	assign d_cr = DIFF_W'(stencil.sample_p1) - DIFF_W'(stencil.sample_center);
	assign d_pr = DIFF_W'(stencil.sample_p2) - DIFF_W'(stencil.sample_p1);
	assign w_eff = (32'(stencil.flattening) > ONE) ? ONE[FLAT_W-1:0] : stencil.flattening;

	ppmfr_mc_slope u_slope_m (.dl(d_ml), .dr(d_cl), .slope(sm));
	ppmfr_mc_slope u_slope_0 (.dl(d_cl), .dr(d_cr), .slope(s0));
	ppmfr_mc_slope u_slope_p (.dl(d_cr), .dr(d_pr), .slope(sp));

	logic signed [SLOPE_W-1:0]  sm_s1, s0_s1, sp_s1;
	logic signed [SAMPLE_W-1:0] m1_s1, c_s1, p1_s1;
	logic        [FLAT_W-1:0]   w_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s1 <= sm;
			s0_s1 <= s0;
			sp_s1 <= sp;
			m1_s1 <= stencil.sample_m1;
			c_s1  <= stencil.sample_center;
			p1_s1 <= stencil.sample_p1;
			w_s1  <= w_eff;
		end
	end

	// stage 2: faces times twelve and their distance from twelve times the center
	logic signed [FACE_W-1:0] up12, lo12, c12;
	logic signed [FACE_W-1:0] up12_s2, lo12_s2, up_d_s2, lo_d_s2;
	logic signed [SAMPLE_W-1:0] c_s2;
	logic        [FLAT_W-1:0]   w_s2;

	always_comb begin
		up12 = 40'sd6 * (FACE_W'(p1_s1) + FACE_W'(c_s1)) + FACE_W'(s0_s1) - FACE_W'(sp_s1);
		lo12 = 40'sd6 * (FACE_W'(c_s1) + FACE_W'(m1_s1)) + FACE_W'(sm_s1) - FACE_W'(s0_s1);
		c12  = 40'sd12 * FACE_W'(c_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up12_s2 <= up12;
			lo12_s2 <= lo12;
			up_d_s2 <= c12 - up12;
			lo_d_s2 <= c12 - lo12;
			c_s2    <= c_s1;
			w_s2    <= w_s1;
		end
	end

	// stage 3: flattening products
	logic signed [FLAT_W:0]   w_sgn;
	logic signed [PROD_W-1:0] up_p_s3, lo_p_s3;
	logic signed [FACE_W-1:0] up12_s3, lo12_s3;
	logic signed [SAMPLE_W-1:0] c_s3;

	assign w_sgn = $signed({1'b0, w_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			up_p_s3 <= PROD_W'(up_d_s2) * PROD_W'(w_sgn);
			lo_p_s3 <= PROD_W'(lo_d_s2) * PROD_W'(w_sgn);
			up12_s3 <= up12_s2;
			lo12_s3 <= lo12_s2;
			c_s3    <= c_s2;
		end
	end

	// stage 4: the flattened face over twelve, rounded, is floor of (t+6)/4 over three;
	// biased so the divide sees a non-negative dividend
	logic signed [PROD_W-1:0] up_sh, lo_sh;
	logic signed [FACE_W-1:0] up_t, lo_t;
	logic        [FACE_W-1:0] up_u_s4, lo_u_s4;
	logic signed [SAMPLE_W-1:0] c_s4;

	always_comb begin
		up_sh = up_p_s3 >>> FRAC_BITS;
		lo_sh = lo_p_s3 >>> FRAC_BITS;
		up_t  = (up12_s3 + $signed(up_sh[FACE_W-1:0]) + 40'sd6) >>> 2;
		lo_t  = (lo12_s3 + $signed(lo_sh[FACE_W-1:0]) + 40'sd6) >>> 2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_u_s4 <= up_t + DIV_BIAS;
			lo_u_s4 <= lo_t + DIV_BIAS;
			c_s4    <= c_s3;
		end
	end

	// stages 5 to 7: long division by three, quotient digits replace dividend digits
	localparam int HI_A = FACE_W - 1;
	localparam int LO_A = FACE_W - 2*DIV_A_DIG;
	localparam int LO_B = LO_A - 2*DIV_B_DIG;

	logic [2*DIV_A_DIG-1:0] up_qa, lo_qa;
	logic [2*DIV_B_DIG-1:0] up_qb, lo_qb;
	logic [2*DIV_C_DIG-1:0] up_qc, lo_qc;
	logic [1:0] up_ra, lo_ra, up_rb, lo_rb, up_rc, lo_rc;
	logic [FACE_W-1:0] up_u_s5, lo_u_s5, up_u_s6, lo_u_s6;
	logic [1:0] up_r_s5, lo_r_s5, up_r_s6, lo_r_s6;
	logic signed [SAMPLE_W-1:0] c_s5, c_s6;

	ppmfr_div3_step #(.NDIG(DIV_A_DIG)) u_div_up_a (
		.rem_in(2'd0), .dig_in(up_u_s4[HI_A:LO_A]), .quo(up_qa), .rem_out(up_ra));
	ppmfr_div3_step #(.NDIG(DIV_A_DIG)) u_div_lo_a (
		.rem_in(2'd0), .dig_in(lo_u_s4[HI_A:LO_A]), .quo(lo_qa), .rem_out(lo_ra));

	always_ff @(posedge clk) begin
		if (en) begin
			up_u_s5 <= {up_qa, up_u_s4[LO_A-1:0]};
			lo_u_s5 <= {lo_qa, lo_u_s4[LO_A-1:0]};
			up_r_s5 <= up_ra;
			lo_r_s5 <= lo_ra;
			c_s5    <= c_s4;
		end
	end

	ppmfr_div3_step #(.NDIG(DIV_B_DIG)) u_div_up_b (
		.rem_in(up_r_s5), .dig_in(up_u_s5[LO_A-1:LO_B]), .quo(up_qb), .rem_out(up_rb));
	ppmfr_div3_step #(.NDIG(DIV_B_DIG)) u_div_lo_b (
		.rem_in(lo_r_s5), .dig_in(lo_u_s5[LO_A-1:LO_B]), .quo(lo_qb), .rem_out(lo_rb));

	always_ff @(posedge clk) begin
		if (en) begin
			up_u_s6 <= {up_u_s5[HI_A:LO_A], up_qb, up_u_s5[LO_B-1:0]};
			lo_u_s6 <= {lo_u_s5[HI_A:LO_A], lo_qb, lo_u_s5[LO_B-1:0]};
			up_r_s6 <= up_rb;
			lo_r_s6 <= lo_rb;
			c_s6    <= c_s5;
		end
	end

	ppmfr_div3_step #(.NDIG(DIV_C_DIG)) u_div_up_c (
		.rem_in(up_r_s6), .dig_in(up_u_s6[LO_B-1:0]), .quo(up_qc), .rem_out(up_rc));
	ppmfr_div3_step #(.NDIG(DIV_C_DIG)) u_div_lo_c (
		.rem_in(lo_r_s6), .dig_in(lo_u_s6[LO_B-1:0]), .quo(lo_qc), .rem_out(lo_rc));

	logic signed [FACE_W-1:0] up_s7, lo_s7;
	logic signed [SAMPLE_W-1:0] c_s7;
	logic [1:0] rem_unused;

	// the final remainders are not needed by the floor
	assign rem_unused = up_rc | lo_rc;

	always_ff @(posedge clk) begin
		if (en) begin
			up_s7 <= $signed({up_u_s6[HI_A:LO_B], up_qc} - DIV_UNBIAS);
			lo_s7 <= $signed({lo_u_s6[HI_A:LO_B], lo_qc} - DIV_UNBIAS);
			c_s7  <= c_s6;
		end
	end

	// stage 8: extremum and overshoot tests
	logic signed [FACE_W:0] dp, dq;
	logic        [FACE_W:0] ap, aq;
	logic                   ext, lo_over, up_over;
	logic signed [FACE_W-1:0] up_s8, lo_s8;
	logic signed [SAMPLE_W-1:0] c_s8;
	logic ext_s8, lo_fix_s8, up_fix_s8;

	always_comb begin
		dp      = (FACE_W+1)'(up_s7) - (FACE_W+1)'(c_s7);
		dq      = (FACE_W+1)'(c_s7) - (FACE_W+1)'(lo_s7);
		ap      = dp[FACE_W] ? (FACE_W+1)'(-dp) : dp;
		aq      = dq[FACE_W] ? (FACE_W+1)'(-dq) : dq;
		ext     = !((!dp[FACE_W] && dp != '0 && !dq[FACE_W] && dq != '0) ||
		            (dp[FACE_W] && dq[FACE_W]));
		lo_over = (FACE_W+2)'(aq) > {ap, 1'b0};
		up_over = (FACE_W+2)'(ap) > {aq, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			up_s8     <= up_s7;
			lo_s8     <= lo_s7;
			c_s8      <= c_s7;
			ext_s8    <= ext;
			lo_fix_s8 <= !ext && lo_over;
			up_fix_s8 <= !ext && !lo_over && up_over;
		end
	end

	// stage 9: corrections, saturation and result register
	logic signed [FACE_W-1:0] c3, up_f, lo_f;
	face_t face_s9;
	logic unused_ok;

	always_comb begin
		c3   = 40'sd3 * FACE_W'(c_s8);
		up_f = up_s8;
		lo_f = lo_s8;
		if (ext_s8) begin
			up_f = FACE_W'(c_s8);
			lo_f = FACE_W'(c_s8);
		end else if (lo_fix_s8) begin
			lo_f = c3 - (up_s8 <<< 1);
		end else if (up_fix_s8) begin
			up_f = c3 - (lo_s8 <<< 1);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [FACE_W-1:0] v);
		logic signed [FACE_W-1:0] t;
		begin
			t = v;
			if (v > SAT_MAX) begin
				t = SAT_MAX;
			end else if (v < SAT_MIN) begin
				t = SAT_MIN;
			end
			return $signed(t[SAMPLE_W-1:0]);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			face_s9.face_upper <= sat(up_f);
			face_s9.face_lower <= sat(lo_f);
		end
	end

	assign unused_ok  = &rem_unused | 1'b1;
	assign face_valid = vld[9] & unused_ok;
	assign face       = face_s9;

endmodule

`default_nettype wire

// File: tb/sv/tb_ppm_face_reconstruction.sv
// tb_ppm_face_reconstruction: self-checking testbench for the ppm face reconstruction pipeline
// holds a face predictor and scoreboard class, the stencil driver and a stalling face receiver
// depends on ppmfr_pkg and ppm_face_reconstruction
`default_nettype none

module tb_ppm_face_reconstruction
	import ppmfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// predicted faces in order, compared against every face transaction
	class face_scoreboard;
		localparam int FRAC_BITS = 16;
		localparam int SHOW_LIMIT = 10;

		face_t expected_faces[$];
		int stencils_noted = 0;
		int faces_checked = 0;
		int mismatches = 0;
		int extrema = 0;
		int lower_fixes = 0;
		int upper_fixes = 0;
		int saturations = 0;

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function longint floor_quot(longint a, longint d);
			longint q;
			q = a / d;
			if ((a % d) != 0 && a < 0)
				q = q - 1;
			return q;
		endfunction

		// doubled mc slope, zero unless both differences share a strict sign
		function longint limited_slope2(longint dl, longint dr);
			longint s, m, t;
			if (!((dl > 0 && dr > 0) || (dl < 0 && dr < 0)))
				return 0;
			s = dl + dr;
			m = mag(s);
			t = 4 * mag(dl);
			if (t < m)
				m = t;
			t = 4 * mag(dr);
			if (t < m)
				m = t;
			return (s < 0) ? -m : m;
		endfunction

		// pull a twelve-times face toward the centre, one rounding, ties up
		function longint flatten_face(longint face12, longint ctr, longint w);
			longint one, delta, q, r, t;
			one = 64'sd1 <<< FRAC_BITS;
			delta = (12 * ctr - face12) * w;
			q = floor_quot(delta, one);
			r = delta - q * one;
			t = face12 + q;
			return floor_quot(2 * t + 12 + ((2 * r >= one) ? 1 : 0), 24);
		endfunction

		function logic signed [SAMPLE_W-1:0] clamp_face(longint v);
			longint c;
			c = v;
			if (c > 64'sd2147483647)
				c = 64'sd2147483647;
			if (c < -64'sd2147483648)
				c = -64'sd2147483648;
			if (c != v)
				saturations++;
			return c[SAMPLE_W-1:0];
		endfunction

		function face_t predict_faces(stencil_t s);
			longint m2, m1, c, p1, p2, w, sm, s0, sp, up, lo, p, q;
			face_t f;
			m2 = longint'($signed(s.sample_m2));
			m1 = longint'($signed(s.sample_m1));
			c  = longint'($signed(s.sample_center));
			p1 = longint'($signed(s.sample_p1));
			p2 = longint'($signed(s.sample_p2));
			w  = longint'(s.flattening);
			// weight above one acts as one
			if (w > (64'sd1 <<< FRAC_BITS))
				w = 64'sd1 <<< FRAC_BITS;
			sm = limited_slope2(m1 - m2, c - m1);
			s0 = limited_slope2(c - m1, p1 - c);
			sp = limited_slope2(p1 - c, p2 - p1);
			up = flatten_face(6 * (p1 + c) + s0 - sp, c, w);
			lo = flatten_face(6 * (c + m1) + sm - s0, c, w);
			// monotonize: flat at an extremum, else overshoot corrections
			p = up - c;
			q = c - lo;
			if (!((p > 0 && q > 0) || (p < 0 && q < 0))) begin
				up = c;
				lo = c;
				extrema++;
			end else if (mag(q) > 2 * mag(p)) begin
				lo = 3 * c - 2 * up;
				lower_fixes++;
			end else if (mag(p) > 2 * mag(q)) begin
				up = 3 * c - 2 * lo;
				upper_fixes++;
			end
			f.face_upper = clamp_face(up);
			f.face_lower = clamp_face(lo);
			return f;
		endfunction

		function void note_stencil(stencil_t s);
			expected_faces.push_back(predict_faces(s));
			stencils_noted++;
		endfunction

		function void flag(string what, longint want, longint got);
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		endfunction

		function void check_face(face_t got);
			face_t want;
			if (expected_faces.size() == 0) begin
				flag("unexpected face transaction, upper", 0, longint'($signed(got.face_upper)));
				return;
			end
			want = expected_faces.pop_front();
			faces_checked++;
			if (got.face_upper !== want.face_upper)
				flag("face_upper", longint'($signed(want.face_upper)),
					longint'($signed(got.face_upper)));
			if (got.face_lower !== want.face_lower)
				flag("face_lower", longint'($signed(want.face_lower)),
					longint'($signed(got.face_lower)));
		endfunction

		function int pending();
			return expected_faces.size();
		endfunction
	endclass

	localparam int CLK_PERIOD = 12;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_STENCILS = 500;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam longint S_MAX = 64'sd2147483647;
	localparam longint S_MIN = -64'sd2147483648;
	localparam longint UNIT = 64'sd65536;
	localparam int W_ONE = 65536;
	localparam int W_TOP = 131071;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     stencil_valid;
	logic     stencil_stall;
	stencil_t stencil;
	logic     face_valid;
	logic     face_stall;
	face_t    face;

	face_scoreboard sb = new;
	int  cycle_count = 0;
	bit  hold_off_req = 1'b0;
	bit  hold_off_done = 1'b0;
	int  directed_count = 0;

	ppm_face_reconstruction #(
		.FRAC_BITS(face_scoreboard::FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.stencil_valid(stencil_valid),
		.stencil_stall(stencil_stall),
		.stencil(stencil),
		.face_valid(face_valid),
		.face_stall(face_stall),
		.face(face)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d faces still expected",
				cycle_count, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// monitor both channels at the edge where a transaction completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (face_valid && !face_stall)
				sb.check_face(face);
			if (stencil_valid && !stencil_stall)
				sb.note_stencil(stencil);
		end
	end

	// receiver stall: free, random and periodic stretches, plus one long hold-off
	initial begin : face_receiver
		int seg_kind, seg_len, period;
		face_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				repeat (HOLD_CYCLES) begin
					face_stall <= 1'b1;
					@(posedge clk);
				end
				hold_off_done = 1'b1;
			end
			seg_kind = $urandom_range(0, 2);
			seg_len = $urandom_range(8, 40);
			period = $urandom_range(2, 5);
			for (int k = 0; k < seg_len; k++) begin
				case (seg_kind)
					0: face_stall <= 1'b0;
					1: face_stall <= ($urandom_range(0, 99) < 35);
					default: face_stall <= ((k % period) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic stencil_t stencil_of(longint m2, longint m1, longint c, longint p1,
			longint p2, int unsigned w);
		stencil_t s;
		s.sample_m2 = m2[SAMPLE_W-1:0];
		s.sample_m1 = m1[SAMPLE_W-1:0];
		s.sample_center = c[SAMPLE_W-1:0];
		s.sample_p1 = p1[SAMPLE_W-1:0];
		s.sample_p2 = p2[SAMPLE_W-1:0];
		s.flattening = w[FLAT_W-1:0];
		return s;
	endfunction

	function automatic longint rand_sample();
		return longint'($signed($urandom()));
	endfunction

	// random offset of random magnitude, up to about 2^29
	function automatic longint rand_delta();
		return rand_sample() >>> $urandom_range(2, 31);
	endfunction

	function automatic int unsigned rand_weight();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 0;
			4: return W_ONE;
			5: return $urandom_range(W_ONE + 1, W_TOP);
			default: return $urandom_range(0, W_ONE);
		endcase
	endfunction

	// smooth profiles, steps, peaks and raw noise
	function automatic stencil_t random_stencil();
		longint v[5];
		longint base, d, curv, jump;
		int kind, at;
		kind = $urandom_range(0, 99);
		base = rand_sample();
		d = rand_delta();
		curv = rand_delta() >>> 2;
		jump = rand_delta() <<< 1;
		at = $urandom_range(1, 4);
		for (int k = 0; k < 5; k++) begin
			if (kind < 20)
				v[k] = rand_sample();
			else if (kind < 60)
				v[k] = base + (k - 2) * d + (k - 2) * (k - 2) * curv;
			else if (kind < 85)
				v[k] = base + ((k >= at) ? jump : 0) + (rand_delta() >>> 8);
			else
				v[k] = (k == 2) ? base : base - ((d < 0) ? -d : d) * (k == 1 || k == 3 ? 1 : 2)
					* ((curv < 0) ? -1 : 1);
		end
		return stencil_of(v[0], v[1], v[2], v[3], v[4], rand_weight());
	endfunction

	task automatic offer_stencil(input stencil_t s);
		stencil <= s;
		stencil_valid <= 1'b1;
		@(posedge clk);
		while (stencil_stall)
			@(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			stencil_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_all_faces();
		stencil_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		stencil_t directed[$];
		int sent, burst;
		bit drained_mid;
		arst_n <= 1'b0;
		stencil_valid <= 1'b0;
		stencil <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, flat, ramps, extrema, steps and weights
		directed.push_back(stencil_of(0, 0, 0, 0, 0, 0));
		directed.push_back(stencil_of(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, W_ONE));
		directed.push_back(stencil_of(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 0));
		directed.push_back(stencil_of(-2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT, 0));
		directed.push_back(stencil_of(S_MIN, S_MIN / 2, 0, S_MAX / 2, S_MAX, 0));
		directed.push_back(stencil_of(0, UNIT, 5 * UNIT, UNIT, 0, 0));
		directed.push_back(stencil_of(0, -UNIT, -5 * UNIT, -UNIT, 0, 20000));
		directed.push_back(stencil_of(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 0));
		directed.push_back(stencil_of(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, W_TOP));
		directed.push_back(stencil_of(0, 0, UNIT, 10 * UNIT, 10 * UNIT, 0));
		directed.push_back(stencil_of(10 * UNIT, 10 * UNIT, 9 * UNIT, 0, 0, 0));
		directed.push_back(stencil_of(0, 0, 9 * UNIT, 10 * UNIT, 10 * UNIT, 0));
		directed.push_back(stencil_of(-2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT, W_ONE));
		directed.push_back(stencil_of(-2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT, W_TOP));
		directed.push_back(stencil_of(-2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT, W_ONE + 1));
		directed.push_back(stencil_of(-2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT, W_ONE / 2));
		directed.push_back(stencil_of(0, UNIT, 4 * UNIT, 9 * UNIT, 16 * UNIT, 12345));
		directed.push_back(stencil_of(-2, -1, 0, 1, 2, W_ONE / 2));
		directed.push_back(stencil_of(S_MIN, S_MIN, S_MAX - (1 << 20), S_MAX, S_MAX, 0));
		directed.push_back(stencil_of(S_MAX, S_MAX, S_MIN + (1 << 20), S_MIN, S_MIN, 0));
		directed.push_back(stencil_of(0, S_MAX - 3, S_MAX - 2, S_MAX, S_MAX, 1));
		directed.push_back(stencil_of(0, S_MIN + 3, S_MIN + 2, S_MIN, S_MIN, W_ONE - 1));
		foreach (directed[i]) begin
			offer_stencil(directed[i]);
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 6));
		end
		directed_count = directed.size();
		wait_all_faces();

		// random bursts; the receiver holds off once early on
		hold_off_req = 1'b1;
		sent = 0;
		drained_mid = 1'b0;
		while (sent < RANDOM_STENCILS) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && sent < RANDOM_STENCILS; k++) begin
				offer_stencil(random_stencil());
				sent++;
			end
			if (!drained_mid && sent >= RANDOM_STENCILS / 2) begin
				wait_all_faces();
				drained_mid = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				pause_sender($urandom_range(1, 10));
			end
		end

		// drain and report
		wait_all_faces();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d stencils (%0d directed), %0d faces checked, %0d mismatches",
			sb.stencils_noted, directed_count, sb.faces_checked, sb.mismatches);
		$display("extrema %0d, lower fixes %0d, upper fixes %0d, saturated faces %0d",
			sb.extrema, sb.lower_fixes, sb.upper_fixes, sb.saturations);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
